FILE: design/lmo_pkg.sv
`timescale 1ns / 1ps
// shared widths and constants of the logistic map oscillator
package lmo_pkg;

    localparam int SR_W     = 20;
    localparam int IDX_W    = 5;
    localparam int RATE_W   = 40;
    localparam int GROWTH_W = 33;
    localparam int SEED_W   = 32;
    localparam int LEVEL_W  = 24;
    localparam int OUT_W    = 32;
    localparam int X_W      = 33;
    localparam int PH_W     = 32;
    localparam int DIVD_W   = RATE_W + 16;

    localparam int DEF_INSTANCES = 32;
    localparam int DEF_MAX_ITER  = 4096;

    localparam logic [X_W-1:0]      ONE_Q32    = 33'h1_0000_0000;
    localparam logic [GROWTH_W-1:0] GROWTH_MAX = 33'h1_0000_0000;
    localparam logic [SEED_W-1:0]   SEED_LO    = 32'd429497;
    localparam logic [SEED_W-1:0]   SEED_HI    = 32'd4294537799;
    localparam logic [SR_W-1:0]     SR_RESET   = 20'd48000;

endpackage

FILE: design/lmo_in_if.sv
`timescale 1ns / 1ps
// input channel of the logistic map oscillator
interface lmo_in_if import lmo_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [IDX_W-1:0]           instance_req;
    logic                       reset_gate;
    logic [RATE_W-1:0]          iter_rate;
    logic [GROWTH_W-1:0]        growth;
    logic [SEED_W-1:0]          seed_value;
    logic signed [LEVEL_W-1:0]  level;

    modport source (
        output valid, instance_req, reset_gate, iter_rate, growth, seed_value, level,
        input  ready
    );
    modport sink (
        input  valid, instance_req, reset_gate, iter_rate, growth, seed_value, level,
        output ready
    );
endinterface

FILE: design/lmo_out_if.sv
`timescale 1ns / 1ps
// output channel of the logistic map oscillator
interface lmo_out_if import lmo_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [OUT_W-1:0]  sample_out;

    modport source (
        output valid, sample_out,
        input  ready
    );
    modport sink (
        input  valid, sample_out,
        output ready
    );
endinterface

FILE: design/lmo_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle, for the phase increment
module lmo_div import lmo_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIVD_W-1:0]  i_dividend,
    input  logic [SR_W-1:0]    i_divisor,
    output logic               o_done,
    output logic [DIVD_W-1:0]  o_quotient
);

    localparam int CW = $clog2(DIVD_W + 1);

    logic            r_busy;
    logic            r_done;
    logic [CW-1:0]   r_cnt;
    logic [SR_W-1:0] r_div;
    logic [SR_W-1:0] r_rem;
    logic [DIVD_W-1:0] r_quo;

    logic [SR_W:0]   rem_sh;
    logic            ge;
    logic [SR_W:0]   rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_quo[DIVD_W-1]};
        ge      = rem_sh >= {1'b0, r_div};
        rem_sub = rem_sh - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DIVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[SR_W-1:0] : rem_sh[SR_W-1:0];
            r_quo <= {r_quo[DIVD_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: design/logistic_map_chaos_oscillator.sv
`timescale 1ns / 1ps
// logistic map oscillator, top level
//
// channels: i_in takes one audio sample transaction for one instance, o_out returns
// one sample_out transaction for it, both valid/ready. i_cfg_we/i_cfg_wdata write
// sample_rate; the user must do so only while the block is idle (not enforced).
// per-instance state: map value and phase in one memory with a registered read,
// started flags in flops. one transaction is worked at a time.
// steps: a reset gate or an out-of-range instance goes from S_LOAD to S_MUL and
// S_OUT; otherwise the bit-serial phase divider runs in S_DIV, then S_PREP, then
// S_MAPA and S_MAPB for each map step due (at most MAX_ITERATIONS), using the
// shared multiplier pair, then S_MUL and S_OUT. the next transaction can be
// taken the cycle after the result register loads.
// i_in.ready is high only between transactions; a finished result waits in the
// output register while the next transaction is taken, and the block holds its
// last stage if that register is still full when the receiver stalls.
// reset: sample_rate goes to 48000 and all instances read as never started, so
// first use seeds them; no clearing pass.
module logistic_map_chaos_oscillator import lmo_pkg::*; #(
    parameter int INSTANCES      = DEF_INSTANCES,
    parameter int MAX_ITERATIONS = DEF_MAX_ITER
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [SR_W-1:0] i_cfg_wdata,
    lmo_in_if.sink          i_in,
    lmo_out_if.source       o_out
);

    localparam int AW   = (INSTANCES > 1) ? $clog2(INSTANCES) : 1;
    localparam int XIW  = 9;
    localparam int NW   = $clog2(MAX_ITERATIONS + 1);
    localparam int WHW  = DIVD_W + 1 - PH_W;
    localparam logic [XIW-1:0] INST_L = XIW'(INSTANCES);
    localparam logic [WHW-1:0] MAX_L  = WHW'(MAX_ITERATIONS);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_LOAD  = 8'b0000_0010,
        S_DIV   = 8'b0000_0100,
        S_PREP  = 8'b0000_1000,
        S_MAPA  = 8'b0001_0000,
        S_MAPB  = 8'b0010_0000,
        S_MUL   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic [X_W-1:0]  x;
        logic [PH_W-1:0] phase;
    } t_entry;

    t_state r_state, n_state;

    t_entry r_mem [INSTANCES];
    t_entry r_rd;

    logic [INSTANCES-1:0]        r_started;
    logic [SR_W-1:0]             r_sample_rate;

    logic [AW-1:0]               r_addr;
    logic                        r_inr;
    logic                        r_gate;
    logic [RATE_W-1:0]           r_rate;
    logic [GROWTH_W-1:0]         r_growth;
    logic [SEED_W-1:0]           r_seed;
    logic signed [LEVEL_W-1:0]   r_level;

    logic [X_W-1:0]              r_x;
    logic [PH_W-1:0]             r_phase;
    logic [NW-1:0]               r_cnt;
    logic [2*X_W-1:0]            r_m1;
    logic signed [X_W+LEVEL_W+1:0] r_prod;

    logic                        r_ovalid;
    logic signed [OUT_W-1:0]     r_odata;

    logic                        accept;
    logic [XIW-1:0]              idx_x;
    logic                        div_start;
    logic                        div_done;
    logic [DIVD_W-1:0]           quo;
    logic [SR_W-1:0]             sr_eff;
    logic [DIVD_W:0]             total;
    logic [WHW-1:0]              whole;
    logic [WHW-1:0]              n_steps;
    logic [X_W-1:0]              one_minus;
    logic [GROWTH_W+PH_W-1:0]    m2;
    logic [GROWTH_W+PH_W-31:0]   nx;
    logic [X_W-1:0]              nx_clamped;
    logic signed [X_W+1:0]       bip;
    logic signed [X_W+1:0]       shifted;
    logic signed [OUT_W-1:0]     sat;
    logic                        seeded;
    logic                        out_free;

    assign accept    = i_in.valid && i_in.ready;
    assign idx_x     = XIW'(i_in.instance_req);
    assign sr_eff    = (r_sample_rate == '0) ? SR_W'(1) : r_sample_rate;
    assign div_start = r_state == S_LOAD && r_inr && !r_gate;
    assign seeded    = r_gate || !r_started[r_addr];
    assign out_free  = !r_ovalid || o_out.ready;

    always_comb begin
        total      = {1'b0, quo} + (DIVD_W + 1)'(r_phase);
        whole      = total[DIVD_W:PH_W];
        n_steps    = (whole > MAX_L) ? MAX_L : whole;
        one_minus  = ONE_Q32 - r_x;
        m2         = (GROWTH_W+PH_W)'(r_growth) * (GROWTH_W+PH_W)'(r_m1[2*PH_W-1:PH_W]);
        nx         = m2[GROWTH_W+PH_W-1:30];
        nx_clamped = (nx > (GROWTH_W+PH_W-30)'(ONE_Q32)) ? ONE_Q32 : nx[X_W-1:0];
        bip        = $signed({1'b0, r_x, 1'b0}) - $signed({2'b00, ONE_Q32});
        shifted    = r_prod[X_W+LEVEL_W+1:24];
        if (shifted > $signed((X_W+2)'(32'h7FFF_FFFF))) begin
            sat = 32'sh7FFF_FFFF;
        end else if (shifted < -$signed((X_W+2)'(33'h0_8000_0000))) begin
            sat = 32'sh8000_0000;
        end else begin
            sat = shifted[OUT_W-1:0];
        end
    end

    lmo_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_rate, 16'd0}),
        .i_divisor  (sr_eff),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_LOAD;
            end
            S_LOAD: begin
                n_state = (r_inr && !r_gate) ? S_DIV : S_MUL;
            end
            S_DIV: begin
                if (div_done) n_state = S_PREP;
            end
            S_PREP: begin
                n_state = (n_steps == '0) ? S_MUL : S_MAPA;
            end
            S_MAPA: begin
                n_state = S_MAPB;
            end
            S_MAPB: begin
                n_state = (r_cnt == NW'(1)) ? S_MUL : S_MAPA;
            end
            S_MUL: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_started     <= '0;
            r_sample_rate <= SR_RESET;
            r_ovalid      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_sample_rate <= i_cfg_wdata;
            if (r_state == S_LOAD && r_inr) r_started[r_addr] <= 1'b1;
            if (r_state == S_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // state memory, registered read
    always_ff @(posedge i_clk) begin
        if (accept) r_rd <= r_mem[idx_x[AW-1:0]];
        if (r_state == S_MUL && r_inr) r_mem[r_addr] <= '{x: r_x, phase: r_phase};
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_addr   <= idx_x[AW-1:0];
                    r_inr    <= idx_x < INST_L;
                    r_gate   <= i_in.reset_gate;
                    r_rate   <= i_in.iter_rate;
                    r_growth <= (i_in.growth > GROWTH_MAX) ? GROWTH_MAX : i_in.growth;
                    r_seed   <= (i_in.seed_value < SEED_LO) ? SEED_LO :
                                (i_in.seed_value > SEED_HI) ? SEED_HI : i_in.seed_value;
                    r_level  <= i_in.level;
                end
            end
            S_LOAD: begin
                r_x     <= seeded ? X_W'(r_seed) : r_rd.x;
                r_phase <= seeded ? '0 : r_rd.phase;
            end
            S_DIV: begin
            end
            S_PREP: begin
                r_cnt   <= n_steps[NW-1:0];
                r_phase <= (whole > MAX_L) ? '0 : total[PH_W-1:0];
            end
            S_MAPA: begin
                r_m1 <= (2*X_W)'(r_x) * (2*X_W)'(one_minus);
            end
            S_MAPB: begin
                r_x   <= nx_clamped;
                r_cnt <= r_cnt - NW'(1);
            end
            S_MUL: begin
                r_prod <= (X_W+LEVEL_W+2)'(bip) * (X_W+LEVEL_W+2)'(r_level);
            end
            S_OUT: begin
                if (out_free) r_odata <= r_inr ? sat : '0;
            end
            default: begin
            end
        endcase
    end

    assign i_in.ready       = r_state == S_IDLE;
    assign o_out.valid      = r_ovalid;
    assign o_out.sample_out = r_odata;

endmodule

FILE: design/lmo_checker.sv
`timescale 1ns / 1ps
// port checker for the logistic map oscillator, bound to the top level
module lmo_checker import lmo_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    lmo_in_if.sink     i_in,
    lmo_out_if.source  o_out
);

    // output register is empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");

    // one transaction at a time
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("input ready right after a transaction");

    // no result appears in the cycle right after a transaction is taken
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !$rose(o_out.valid))
        else $error("result too early");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.sample_out))
        else $error("stalled result changed");

endmodule

bind logistic_map_chaos_oscillator lmo_checker u_lmo_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_in    (i_in),
    .o_out   (o_out)
);
